// ===== design/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache lookup.
// No dependencies; imported by sacl_way_sel, set_assoc_cache_lru_lookup_top, sacl_lookup_checker and testbench.
package sacl_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;
  localparam int RES_WAY_W  = 2;

  // result FIFO: three entries, pointers wrap at the last index
  localparam logic [1:0] RES_FIFO_LAST = 2'd2;
  localparam logic [1:0] RES_FIFO_FULL = 2'd3;

  typedef struct packed {
    logic [RES_WAY_W-1:0] way;
    logic                 hit;
  } sacl_res_t;

endpackage

// ===== design/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read during write to the same address returns the old data.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sacl_way_sel.sv =====
// Per-set way selection: tag match, fill/victim choice and LRU rank update.
// Depends on sacl_pkg; purely combinational.
module sacl_way_sel #(
  parameter int WAYS   = 4,
  parameter int TAG_W  = 28,
  parameter int RANK_W = 2,
  parameter int WAY_W  = 2
) (
  input  logic [WAYS-1:0]              valid,
  input  logic [WAYS-1:0][RANK_W-1:0]  rank,
  input  logic [WAYS-1:0][TAG_W-1:0]   tags,
  input  logic [TAG_W-1:0]             tag,
  output logic [WAYS-1:0]              valid_nxt,
  output logic [WAYS-1:0][RANK_W-1:0]  rank_nxt,
  output logic [WAYS-1:0][TAG_W-1:0]   tags_nxt,
  output sacl_pkg::sacl_res_t          res
);

  import sacl_pkg::*;

  localparam logic [RANK_W-1:0] RANK_MRU = RANK_W'(WAYS - 1);

  logic [WAY_W-1:0]   hit_idx;
  logic [WAY_W-1:0]   inv_idx;
  logic [WAY_W-1:0]   lru_idx;
  logic [WAY_W-1:0]   chosen;
  logic               any_hit;
  logic               any_inv;
  logic [RANK_W-1:0]  old_rank;
  logic [WAY_W+1:0]   way_ext;

  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    lru_idx = '0;
    any_hit = 1'b0;
    any_inv = 1'b0;
    // walk downward so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && tags[w] == tag) begin
        hit_idx = WAY_W'(w);
        any_hit = 1'b1;
      end
      if (!valid[w]) begin
        inv_idx = WAY_W'(w);
        any_inv = 1'b1;
      end
      if (rank[w] == '0) begin
        lru_idx = WAY_W'(w);
      end
    end

    if (any_hit) begin
      chosen = hit_idx;
    end else if (any_inv) begin
      chosen = inv_idx;
    end else begin
      chosen = lru_idx;
    end

    old_rank = rank[chosen];
    for (int k = 0; k < WAYS; k++) begin
      if (WAY_W'(k) == chosen) begin
        rank_nxt[k]  = RANK_MRU;
        valid_nxt[k] = 1'b1;
        tags_nxt[k]  = tag;
      end else begin
        rank_nxt[k]  = (rank[k] > old_rank) ? rank[k] - 1'b1 : rank[k];
        valid_nxt[k] = valid[k];
        tags_nxt[k]  = tags[k];
      end
    end

    way_ext  = {2'b00, chosen};
    res.hit  = any_hit;
    res.way  = way_ext[RES_WAY_W-1:0];
  end

endmodule

// ===== design/set_assoc_cache_lru_lookup_top.sv =====
// Top level of the set-associative cache lookup with true LRU replacement.
// Depends on sacl_pkg, sacl_ram and sacl_way_sel.
//
//   channel  dir  tdata fields (lsb first)        tuser/tlast
//   in_*     in   address[31:0]                  none
//   out_*    out  hit[0], way[2:1], zero[7:3]    none
//
// One transfer per cycle while a result FIFO slot is free for it.
// The set row is read from the tag/state RAM on accept and written back the next
// cycle; a back-to-back access to the same set is forwarded around the RAM.
// After reset a clearing pass writes every set row while in_tready is held low.
// Results queue in a 3-entry FIFO; out_tready reaches in_tready only through cnt_r.
module set_assoc_cache_lru_lookup_top #(
  parameter int SET_COUNT = 16,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0]   in_tdata,   // address[31:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sacl_pkg::OUT_DATA_W-1:0]  out_tdata   // hit[0], way[2:1], zero[7:3]
);

  import sacl_pkg::*;

  localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int EFF_BITS = (ADDR_BITS < IN_DATA_W) ? ADDR_BITS : IN_DATA_W;
  localparam int SHIFT    = $clog2(SET_COUNT + 1) - 1;
  localparam int TAG_W    = (EFF_BITS > SHIFT) ? EFF_BITS - SHIFT : 1;
  localparam int RANK_OFS = WAYS;
  localparam int TAG_OFS  = WAYS * (1 + RANK_W);
  localparam int ROW_W    = WAYS * (1 + RANK_W + TAG_W);

  localparam logic [IN_DATA_W-1:0] ADDR_MASK = (EFF_BITS >= IN_DATA_W) ? '1 :
                                               ((IN_DATA_W'(1) << EFF_BITS) - 1'b1);
  localparam logic [SET_W-1:0]     SET_MASK  = SET_W'(SET_COUNT - 1);
  localparam logic [SET_W-1:0]     SET_LAST  = SET_W'(SET_COUNT - 1);

  // input split
  logic [IN_DATA_W-1:0] addr_m;
  logic [IN_DATA_W-1:0] addr_sh;
  logic [SET_W-1:0]     in_set;
  logic [TAG_W-1:0]     in_tag;
  logic                 in_acc;

  // lookup stage
  logic                 s1_vld_r;
  logic [SET_W-1:0]     s1_set_r;
  logic [TAG_W-1:0]     s1_tag_r;
  logic                 fwd_r;
  logic [ROW_W-1:0]     fwd_row_r;
  logic [ROW_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]     row_eff;
  logic [ROW_W-1:0]     row_nxt;
  logic [ROW_W-1:0]     row_clr;

  logic [WAYS-1:0]              rd_valid;
  logic [WAYS-1:0][RANK_W-1:0]  rd_rank;
  logic [WAYS-1:0][TAG_W-1:0]   rd_tag;
  logic [WAYS-1:0]              wr_valid;
  logic [WAYS-1:0][RANK_W-1:0]  wr_rank;
  logic [WAYS-1:0][TAG_W-1:0]   wr_tag;
  sacl_res_t                    s1_res;

  // clearing pass
  logic                 clr_r;
  logic [SET_W-1:0]     clr_idx_r;

  // RAM write port
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;

  // result FIFO
  sacl_res_t            res_mem_r [3];
  logic [1:0]           wr_ptr_r;
  logic [1:0]           rd_ptr_r;
  logic [1:0]           cnt_r;
  logic [1:0]           cnt_nxt;
  logic [2:0]           occ;
  logic                 pop;

  assign addr_m  = in_tdata & ADDR_MASK;
  assign addr_sh = addr_m >> SHIFT;
  assign in_set  = addr_m[SET_W-1:0] & SET_MASK;
  assign in_tag  = addr_sh[TAG_W-1:0];

  // reserve a FIFO slot for every item in flight
  assign occ       = {1'b0, cnt_r} + {2'b00, s1_vld_r};
  assign in_tready = !clr_r && (occ <= 3'd2);
  assign in_acc    = in_tvalid && in_tready;

  assign row_eff = fwd_r ? fwd_row_r : ram_rdata;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_valid[w] = row_eff[w];
      rd_rank[w]  = row_eff[RANK_OFS + w * RANK_W +: RANK_W];
      rd_tag[w]   = row_eff[TAG_OFS + w * TAG_W +: TAG_W];
    end
  end

  sacl_way_sel #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W),
    .WAY_W  (WAY_W)
  ) u_way_sel (
    .valid     (rd_valid),
    .rank      (rd_rank),
    .tags      (rd_tag),
    .tag       (s1_tag_r),
    .valid_nxt (wr_valid),
    .rank_nxt  (wr_rank),
    .tags_nxt  (wr_tag),
    .res       (s1_res)
  );

  always_comb begin
    row_nxt = '0;
    row_clr = '0;
    for (int w = 0; w < WAYS; w++) begin
      row_nxt[w]                               = wr_valid[w];
      row_nxt[RANK_OFS + w * RANK_W +: RANK_W] = wr_rank[w];
      row_nxt[TAG_OFS + w * TAG_W +: TAG_W]    = wr_tag[w];
      row_clr[RANK_OFS + w * RANK_W +: RANK_W] = RANK_W'(w);
    end
  end

  assign ram_we    = clr_r || s1_vld_r;
  assign ram_waddr = clr_r ? clr_idx_r : s1_set_r;
  assign ram_wdata = clr_r ? row_clr : row_nxt;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {(OUT_DATA_W - $bits(sacl_res_t))'(0), res_mem_r[rd_ptr_r]};
  assign cnt_nxt    = cnt_r + {1'b0, s1_vld_r} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      s1_vld_r  <= 1'b0;
      fwd_r     <= 1'b0;
      cnt_r     <= 2'd0;
      wr_ptr_r  <= 2'd0;
      rd_ptr_r  <= 2'd0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == SET_LAST) begin
          clr_r <= 1'b0;
        end
      end
      s1_vld_r <= in_acc;
      fwd_r    <= in_acc && s1_vld_r && (in_set == s1_set_r);
      cnt_r    <= cnt_nxt;
      if (s1_vld_r) begin
        wr_ptr_r <= (wr_ptr_r == RES_FIFO_LAST) ? 2'd0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == RES_FIFO_LAST) ? 2'd0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
    end
    fwd_row_r <= row_nxt;
    if (s1_vld_r) begin
      res_mem_r[wr_ptr_r] <= s1_res;
    end
  end

  a_fifo_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_vld_r && cnt_r == RES_FIFO_FULL))
    else $error("result FIFO overflow");

  a_accept_to_lookup : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_vld_r)
    else $error("accepted transfer did not reach lookup stage");

  a_clear_idle : assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (cnt_r == 2'd0 && !s1_vld_r))
    else $error("transfer in flight during clearing pass");

endmodule

// ===== test/sacl_lookup_checker.sv =====
// Scoreboard for the set-associative LRU cache lookup: watches both stream channels,
// keeps its own copy of valid bits, tags and LRU ranks, and compares every result.
// Depends on sacl_pkg for the result layout.
module sacl_lookup_checker #(
  parameter int SET_COUNT = 16,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sacl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                               mismatch_cnt,
  output int                               pending
);
  import sacl_pkg::*;

  localparam int          SET_SHIFT = $clog2(SET_COUNT + 1) - 1;
  localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << ADDR_BITS) - 64'd1);

  bit          line_ok  [SET_COUNT][WAYS];
  logic [63:0] line_tags[SET_COUNT][WAYS];
  int          lru_age  [SET_COUNT][WAYS];
  sacl_res_t   lookup_q[$];

  task automatic clear_cache();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_ok[s][w]   = 1'b0;
        line_tags[s][w] = '0;
        lru_age[s][w]   = w;
      end
    end
  endtask

  // touched way becomes MRU; ways ranked above it slide down one
  task automatic promote_way(input int s, input int w);
    int old_rank;
    old_rank = lru_age[s][w];
    for (int k = 0; k < WAYS; k++) begin
      if (lru_age[s][k] > old_rank) lru_age[s][k]--;
    end
    lru_age[s][w] = WAYS - 1;
  endtask

  task automatic cache_access(input logic [IN_DATA_W-1:0] addr, output sacl_res_t res);
    logic [63:0] a;
    logic [63:0] tg;
    int          s;
    int          pick;
    bit          found;
    a     = 64'(addr) & ADDR_MASK;
    s     = int'(a & 64'(SET_COUNT - 1));
    tg    = a >> SET_SHIFT;
    pick  = 0;
    found = 1'b0;
    if (s >= SET_COUNT) s = 0;
    for (int w = 0; w < WAYS && !found; w++) begin
      if (line_ok[s][w] && line_tags[s][w] == tg) begin
        pick  = w;
        found = 1'b1;
      end
    end
    res.hit = found;
    if (!found) begin
      for (int w = 0; w < WAYS && !found; w++) begin
        if (!line_ok[s][w]) begin
          pick  = w;
          found = 1'b1;
        end
      end
      // all ways valid: victim is rank 0
      for (int w = 0; w < WAYS && !found; w++) begin
        if (lru_age[s][w] == 0) begin
          pick  = w;
          found = 1'b1;
        end
      end
      line_ok[s][pick]   = 1'b1;
      line_tags[s][pick] = tg;
    end
    promote_way(s, pick);
    res.way = pick[RES_WAY_W-1:0];
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    if (mismatch_cnt < 10) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : monitor
    sacl_res_t want;
    sacl_res_t got;
    if (!rst_n) begin
      clear_cache();
      lookup_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        cache_access(in_tdata, want);
        lookup_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_WAY_W:0];
        if (lookup_q.size() == 0) begin
          flag_mismatch("unexpected transfer, tdata", -1, int'(out_tdata));
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit) flag_mismatch("hit", want.hit, got.hit);
          if (got.way !== want.way) flag_mismatch("way", want.way, got.way);
          if (out_tdata[OUT_DATA_W-1:RES_WAY_W+1] !== '0) begin
            flag_mismatch("padding", 0, int'(out_tdata[OUT_DATA_W-1:RES_WAY_W+1]));
          end
        end
      end
    end
    pending = lookup_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the cache lookup testbench: clock, reset, address stimulus and output backpressure.
// Depends on sacl_pkg, set_assoc_cache_lru_lookup_top and sacl_lookup_checker.
module testbench;
  import sacl_pkg::*;

  localparam int N_ITEMS    = 750;
  localparam int QUIET_TAIL = 80;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   in_fire = 1'b0;
  int                     mismatch_cnt;
  int                     pending;
  int                     sent_cnt = 0;
  bit                     quiet = 1'b0;
  bit                     hold_done = 1'b0;
  logic [27:0]            tag_pool[8];
  logic [IN_DATA_W-1:0]   last_addr = '0;

  set_assoc_cache_lru_lookup_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sacl_lookup_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatch_cnt (mismatch_cnt),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_addr(input logic [IN_DATA_W-1:0] addr);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(negedge clk); while (!in_fire);
    last_addr = addr;
    sent_cnt++;
    quiet = (sent_cnt >= N_ITEMS - QUIET_TAIL);
  endtask

  // mostly a small tag pool on a few hot sets so lines hit and get evicted
  function automatic logic [IN_DATA_W-1:0] next_addr();
    int         r;
    logic [3:0] s;
    r = $urandom_range(0, 99);
    if (r < 20) return IN_DATA_W'($urandom);
    if (r < 30) return last_addr;
    s = (r < 65) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    return {tag_pool[3'($urandom_range(0, 7))], s};
  endfunction

  // receiver: random stall bursts, one long hold-off to back up the pipe
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && sent_cnt >= 200) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (64) @(negedge clk);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
    end
  end

  initial begin
    int wait_cycles;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    for (int i = 0; i < 8; i++) tag_pool[i] = 28'($urandom);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: address extremes, consecutive same-set accesses, fill and LRU eviction
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0000_0000);
    send_addr(32'h8000_0000);
    send_addr(32'h0000_000F);
    send_addr(32'h0000_0015);
    send_addr(32'h0000_0025);
    send_addr(32'h0000_0035);
    send_addr(32'h0000_0045);
    send_addr(32'h0000_0025);
    send_addr(32'h0000_0055);
    send_addr(32'h0000_0015);
    send_addr(32'h0000_0035);
    send_addr(32'h0000_0045);
    send_addr(32'h0000_0055);
    send_addr(32'h0000_0015);
    send_addr(32'h7FFF_FFF0);
    send_addr(32'hAAAA_AAAA);
    send_addr(32'h5555_5555);

    while (sent_cnt < N_ITEMS) send_addr(next_addr());
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_lookup_top.f =====
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_way_sel.sv
design/set_assoc_cache_lru_lookup_top.sv
test/sacl_lookup_checker.sv
test/testbench.sv
